// File: hdl/vwbd_pkg.sv
// vwbd_pkg: shared constants for the vertex weld-by-distance unit
// covers register map, field widths and parameter defaults; no dependencies
package vwbd_pkg;

	// parameter defaults
	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF = 24;

	// result index fields are always this wide
	localparam int PIDX_W = 10;

	// squared-distance threshold register
	localparam int              THR_W     = 50;
	localparam logic [THR_W-1:0] THR_RESET = 50'd3355;

	// apb port: one 64-bit register at byte address 8*i
	localparam int         APB_DW      = 64;
	localparam int         APB_AW      = 4;
	localparam int         REG_SHIFT   = 3;
	localparam logic [0:0] REG_THR_IDX = 1'b0;

endpackage

// File: hdl/vertex_weld_by_distance_unit.sv
// vertex_weld_by_distance_unit: welds each vertex to the first earlier vertex within
// the squared-distance threshold, brute-force scan over the on-chip vertex store
// a request with nothing stored, or with the store full, goes straight to the result; else
//   each stored vertex is scanned in order until the first match
// one vertex at a time: each stored vertex scanned passes the x, y and z square steps
//   of the single shared squarer and then the add and compare
// reset: vertex count zero, threshold 3355, store contents undefined (no clearing pass)
module vertex_weld_by_distance_unit
	import vwbd_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// vertex request channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	input  logic signed [COORD_BITS-1:0] z_coord,
	input  logic                         first_of_mesh,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [PIDX_W-1:0]            point_index,
	output logic [PIDX_W-1:0]            mapped_index,
	output logic                         merged,
	output logic                         overflow,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [APB_AW-1:0]            paddr,
	input  logic [APB_DW-1:0]            pwdata,
	output logic [APB_DW-1:0]            prdata,
	output logic                         pready
);

	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int AB_W  = COORD_BITS + 1;
	localparam int SQ_W  = 2 * AB_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;
	localparam int EXT_W = IDX_W + PIDX_W;

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQX  = 3'd1;
	localparam logic [2:0] ST_SQY  = 3'd2;
	localparam logic [2:0] ST_SQZ  = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	// vertex store
	logic [COORD_BITS-1:0] mem_x   [MAX_POINTS];
	logic [COORD_BITS-1:0] mem_y   [MAX_POINTS];
	logic [COORD_BITS-1:0] mem_z   [MAX_POINTS];
	logic [IDX_W-1:0]      mem_rep [MAX_POINTS];

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [THR_W-1:0]      thr_q;
	logic [IDX_W-1:0]      cur_q;
	logic [IDX_W-1:0]      scan_q;
	logic [IDX_W-1:0]      rep_q;
	logic                  hit_q;
	logic                  ovf_q;
	logic [COORD_BITS-1:0] x_q, y_q, z_q;
	logic [COORD_BITS-1:0] rx_q, ry_q, rz_q;
	logic [IDX_W-1:0]      rrep_q;
	logic [SQ_W-1:0]       sq_q;
	logic [SUM_W-1:0]      acc_q;

	logic                  out_valid_q;
	logic [PIDX_W-1:0]     point_index_q;
	logic [PIDX_W-1:0]     mapped_index_q;
	logic                  merged_q;
	logic                  overflow_q;

	logic                  accept;
	logic                  cfg_wr;
	logic [CNT_W-1:0]      eff_cnt;
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic [IDX_W:0]        scan_nxt;
	logic                  scan_last;
	logic [COORD_BITS-1:0] sq_a, sq_b;
	logic [AB_W-1:0]       diff_w;
	logic [AB_W-1:0]       abs_w;
	logic [SQ_W-1:0]       sq_w;
	logic [SUM_W-1:0]      dsum_w;
	logic                  near_w;
	logic                  done_fire;
	logic [EXT_W-1:0]      pidx_ext;
	logic [EXT_W-1:0]      rep_ext;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign eff_cnt  = first_of_mesh ? '0 : cnt_q;

	// apb register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
	                (paddr[APB_AW-1:REG_SHIFT] == REG_THR_IDX);
	assign prdata = (paddr[APB_AW-1:REG_SHIFT] == REG_THR_IDX) ? APB_DW'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	// scan address: entry 0 on a new request, the next entry after each compare
	assign scan_nxt  = {1'b0, scan_q} + 1'b1;
	assign scan_last = (scan_nxt == {1'b0, cur_q});
	assign rd_addr   = (state_q == ST_IDLE) ? '0 : scan_nxt[IDX_W-1:0];
	assign rd_en     = accept || ((state_q == ST_CMP) && !near_w && !scan_last);

	// shared squarer, operand pair chosen by phase
	always_comb begin
		case (state_q)
			ST_SQY: begin
				sq_a = y_q;
				sq_b = ry_q;
			end
			ST_SQZ: begin
				sq_a = z_q;
				sq_b = rz_q;
			end
			default: begin
				sq_a = x_q;
				sq_b = rx_q;
			end
		endcase
	end

	assign diff_w = {sq_a[COORD_BITS-1], sq_a} - {sq_b[COORD_BITS-1], sq_b};
	assign abs_w  = diff_w[AB_W-1] ? (~diff_w + 1'b1) : diff_w;
	assign sq_w   = abs_w * abs_w;

	// final add of the z square and threshold compare
	assign dsum_w = acc_q + SUM_W'(sq_q);
	assign near_w = CMP_W'(dsum_w) < CMP_W'(thr_q);

	assign done_fire = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// store read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rx_q   <= mem_x[rd_addr];
			ry_q   <= mem_y[rd_addr];
			rz_q   <= mem_z[rd_addr];
			rrep_q <= mem_rep[rd_addr];
		end
	end

	// store write port
	always_ff @(posedge clk) begin
		if (done_fire && !ovf_q) begin
			mem_x[cur_q]   <= x_q;
			mem_y[cur_q]   <= y_q;
			mem_z[cur_q]   <= z_q;
			mem_rep[cur_q] <= rep_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (eff_cnt == CNT_W'(MAX_POINTS) || eff_cnt == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SQX;
						end
					end
				end
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: state_q <= ST_SQZ;
				ST_SQZ: state_q <= ST_CMP;
				ST_CMP: begin
					if (near_w || scan_last) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SQX;
					end
				end
				ST_DONE: begin
					if (done_fire) begin
						state_q <= ST_IDLE;
						if (!ovf_q) begin
							cnt_q <= CNT_W'({1'b0, cur_q}) + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request and scan datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= x_coord;
			y_q    <= y_coord;
			z_q    <= z_coord;
			cur_q  <= eff_cnt[IDX_W-1:0];
			rep_q  <= eff_cnt[IDX_W-1:0];
			ovf_q  <= (eff_cnt == CNT_W'(MAX_POINTS));
			hit_q  <= 1'b0;
			scan_q <= '0;
		end
		case (state_q)
			ST_SQX: sq_q <= sq_w;
			ST_SQY: begin
				sq_q  <= sq_w;
				acc_q <= SUM_W'(sq_q);
			end
			ST_SQZ: begin
				sq_q  <= sq_w;
				acc_q <= acc_q + SUM_W'(sq_q);
			end
			ST_CMP: begin
				if (near_w) begin
					hit_q <= 1'b1;
					rep_q <= rrep_q;
				end else begin
					scan_q <= scan_nxt[IDX_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// result register
	assign pidx_ext = {{PIDX_W{1'b0}}, cur_q};
	assign rep_ext  = {{PIDX_W{1'b0}}, rep_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			point_index_q  <= ovf_q ? '0 : pidx_ext[PIDX_W-1:0];
			mapped_index_q <= ovf_q ? '0 : rep_ext[PIDX_W-1:0];
			merged_q       <= !ovf_q && hit_q;
			overflow_q     <= ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign point_index  = point_index_q;
	assign mapped_index = mapped_index_q;
	assign merged       = merged_q;
	assign overflow     = overflow_q;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for vertex_weld_by_distance_unit, with a directed table,
// random meshes, apb threshold writes and readback
// depends on vwbd_pkg and the unit rtl only
module tb_top;
	import vwbd_pkg::*;

	localparam int CW         = COORD_BITS_DEF;
	localparam int MAXP       = MAX_POINTS_DEF;
	localparam int C_HI       = 2 ** (CW - 1) - 1;
	localparam int C_LO       = -(2 ** (CW - 1));
	localparam int THR_IDX    = int'(REG_THR_IDX);
	localparam int SPARE_IDX  = 1;
	localparam int SETTLE_CYC = 10;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 fom;
	} vtx_t;

	typedef struct packed {
		logic [PIDX_W-1:0] pidx;
		logic [PIDX_W-1:0] midx;
		logic              mrg;
		logic              ovf;
	} weld_t;

	typedef struct packed {
		vtx_t  v;
		logic  typed;
		weld_t w;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [CW-1:0] x_coord;
	logic signed [CW-1:0] y_coord;
	logic signed [CW-1:0] z_coord;
	logic                 first_of_mesh;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [PIDX_W-1:0]    point_index;
	logic [PIDX_W-1:0]    mapped_index;
	logic                 merged;
	logic                 overflow;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [APB_DW-1:0]    pwdata;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	// predictor state: vertex store, rep table, count and threshold copy
	logic signed [CW-1:0] vtx_x [MAXP];
	logic signed [CW-1:0] vtx_y [MAXP];
	logic signed [CW-1:0] vtx_z [MAXP];
	logic [PIDX_W-1:0]    vtx_rep [MAXP];
	int                   vtx_count = 0;
	logic [THR_W-1:0]     thr_mirror = THR_RESET;

	weld_t    pending_welds[$];
	weld_t    head_w;
	dir_row_t dir_rows[$];
	int       mismatch_cnt = 0;
	int       send_idle_pct = 0;
	int       ready_stall_pct = 0;

	vertex_weld_by_distance_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.z_coord      (z_coord),
		.first_of_mesh(first_of_mesh),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_index  (point_index),
		.mapped_index (mapped_index),
		.merged       (merged),
		.overflow     (overflow),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#400_000_000;
		$display("Mismatches found");
		$finish;
	end

	// result backpressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
	end

	function automatic logic [63:0] sq_gap(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		longint g;
		g = longint'(a) - longint'(b);
		return 64'(g * g);
	endfunction

	// weld prediction: first stored vertex strictly inside the threshold wins
	task automatic weld_predict(input vtx_t v, output weld_t w);
		logic [63:0] d;
		int          rep;
		logic        hit;
		w = '0;
		if (v.fom) vtx_count = 0;
		if (vtx_count >= MAXP) begin
			w.ovf = 1'b1;
			return;
		end
		rep = vtx_count;
		hit = 1'b0;
		for (int i = 0; i < vtx_count && !hit; i++) begin
			d = sq_gap(v.x, vtx_x[i]) + sq_gap(v.y, vtx_y[i]) + sq_gap(v.z, vtx_z[i]);
			if (d < 64'(thr_mirror)) begin
				rep = vtx_rep[i];
				hit = 1'b1;
			end
		end
		vtx_x[vtx_count]   = v.x;
		vtx_y[vtx_count]   = v.y;
		vtx_z[vtx_count]   = v.z;
		vtx_rep[vtx_count] = PIDX_W'(rep);
		w.pidx = PIDX_W'(vtx_count);
		w.midx = PIDX_W'(rep);
		w.mrg  = hit;
		vtx_count++;
	endtask

	function automatic void note_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatch_cnt++;
		end
	endfunction

	// append a directed row to the table
	function automatic void add_row(input dir_row_t r);
		dir_rows = {dir_rows, r};
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_welds.size() == 0) begin
				$display("%0t: result with none expected, point_index expected none actual %0d",
					$time, point_index);
				mismatch_cnt++;
			end else begin
				head_w = pending_welds.pop_front();
				note_field("point_index", head_w.pidx, point_index);
				note_field("mapped_index", head_w.midx, mapped_index);
				note_field("merged", head_w.mrg, merged);
				note_field("overflow", head_w.ovf, overflow);
			end
		end
	end

	// one vertex request, with optional idle cycles in front
	task automatic send_vertex(input vtx_t v, input logic typed, input weld_t typed_w);
		weld_t w;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid      <= 1'b1;
		x_coord       <= v.x;
		y_coord       <= v.y;
		z_coord       <= v.z;
		first_of_mesh <= v.fom;
		do @(posedge clk); while (!in_ready);
		weld_predict(v, w);
		pending_welds = {pending_welds, (typed ? typed_w : w)};
	endtask

	// stop sending and let every outstanding result drain
	task automatic wait_results_idle();
		in_valid <= 1'b0;
		while (pending_welds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic cfg_read_check();
		logic [THR_W-1:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= APB_AW'(THR_IDX << REG_SHIFT);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata[THR_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== thr_mirror) begin
			$display("%0t: dist_sq_threshold expected %0d actual %0d", $time, thr_mirror, got);
			mismatch_cnt++;
		end
	endtask

	// apb write, then read the threshold back
	task automatic cfg_write(input int idx, input logic [APB_DW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(idx << REG_SHIFT);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == THR_IDX) thr_mirror = val[THR_W-1:0];
		@(posedge clk);
		cfg_read_check();
	endtask

	// random meshes: mostly clustered vertices, some fresh ones and stray restarts
	task automatic run_meshes(input int budget, input int jit, input logic pause_once);
		int   sent;
		int   size;
		int   j;
		logic paused;
		vtx_t v;
		sent   = 0;
		paused = 1'b0;
		while (sent < budget) begin
			size = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
			if (size > budget - sent) size = budget - sent;
			for (int k = 0; k < size; k++) begin
				if (vtx_count > 0 && $urandom_range(0, 99) < 70) begin
					j = $urandom_range(0, vtx_count - 1);
					v.x = vtx_x[j] + CW'(int'($urandom_range(0, 2 * jit)) - jit);
					v.y = vtx_y[j] + CW'(int'($urandom_range(0, 2 * jit)) - jit);
					v.z = vtx_z[j] + CW'(int'($urandom_range(0, 2 * jit)) - jit);
				end else begin
					v.x = CW'($urandom);
					v.y = CW'($urandom);
					v.z = CW'($urandom);
				end
				v.fom = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 99) < 3);
				send_vertex(v, 1'b0, '0);
			end
			sent += size;
			// once, at half the budget when asked, hold off until the unit has returned everything
			if (pause_once && !paused && sent >= budget / 2) begin
				paused = 1'b1;
				wait_results_idle();
			end
		end
	endtask

	function automatic dir_row_t mk_row(input int x, input int y, input int z, input logic f,
			input logic typed, input int p, input int m, input logic mg, input logic ov);
		dir_row_t r;
		r.v.x    = CW'(x);
		r.v.y    = CW'(y);
		r.v.z    = CW'(z);
		r.v.fom  = f;
		r.typed  = typed;
		r.w.pidx = PIDX_W'(p);
		r.w.midx = PIDX_W'(m);
		r.w.mrg  = mg;
		r.w.ovf  = ov;
		return r;
	endfunction

	initial begin
		int   r;
		logic [APB_DW-1:0] word;

		in_valid      <= 1'b0;
		x_coord       <= '0;
		y_coord       <= '0;
		z_coord       <= '0;
		first_of_mesh <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		arst_n        <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// threshold after reset
		cfg_read_check();

		// directed vertices at the reset threshold
		add_row(mk_row(0, 0, 0, 1, 1, 0, 0, 0, 0));
		add_row(mk_row(0, 0, 0, 0, 1, 1, 0, 1, 0));
		add_row(mk_row(C_HI, C_HI, C_HI, 0, 1, 2, 2, 0, 0));
		add_row(mk_row(C_LO, C_LO, C_LO, 0, 1, 3, 3, 0, 0));
		// just inside and just outside the limit around the max corner
		add_row(mk_row(C_HI, C_HI, C_HI - 57, 0, 0, 0, 0, 0, 0));
		add_row(mk_row(C_HI - 58, C_HI, C_HI, 0, 0, 0, 0, 0, 0));
		// distance equal to the threshold does not weld
		add_row(mk_row(51, 27, 5, 0, 0, 0, 0, 0, 0));
		// nearer to the later vertex, but the first match in order wins
		add_row(mk_row(50, 27, 5, 0, 0, 0, 0, 0, 0));
		add_row(mk_row(-1, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk_row(C_LO, C_HI, C_LO, 0, 0, 0, 0, 0, 0));
		add_row(mk_row(C_HI, C_LO, C_HI, 0, 0, 0, 0, 0, 0));
		// restart, then a chain that inherits the first vertex's rep
		add_row(mk_row(100, 200, 300, 1, 1, 0, 0, 0, 0));
		add_row(mk_row(1000, 1000, 1000, 0, 0, 0, 0, 0, 0));
		add_row(mk_row(1040, 1000, 1000, 0, 0, 0, 0, 0, 0));
		add_row(mk_row(1080, 1000, 1000, 0, 0, 0, 0, 0, 0));
		// two single-vertex meshes back to back, then a second vertex in the last one
		add_row(mk_row(-5, -5, -5, 1, 1, 0, 0, 0, 0));
		add_row(mk_row(0, 0, 0, 1, 1, 0, 0, 0, 0));
		add_row(mk_row(0, 0, -33, 0, 0, 0, 0, 0, 0));
		foreach (dir_rows[i]) send_vertex(dir_rows[i].v, dir_rows[i].typed, dir_rows[i].w);
		wait_results_idle();

		// no idling: spare address ignored, max threshold welds every later vertex to its mesh's first
		send_idle_pct   = 0;
		ready_stall_pct = 0;
		cfg_write(SPARE_IDX, {$urandom, $urandom});
		cfg_write(THR_IDX, '1);
		run_meshes(140, 64, 1'b0);
		wait_results_idle();

		// sender mostly idle, zero threshold: nothing ever welds
		send_idle_pct   = 83;
		ready_stall_pct = 0;
		cfg_write(THR_IDX, '0);
		run_meshes(140, 4, 1'b0);
		wait_results_idle();

		// receiver mostly stalled, small random threshold
		send_idle_pct   = 0;
		ready_stall_pct = 83;
		r = $urandom_range(1, 4096);
		cfg_write(THR_IDX, APB_DW'(longint'(r) * r));
		run_meshes(140, r, 1'b1);
		wait_results_idle();

		// both sides idling, large threshold with junk in the upper word bits
		send_idle_pct   = 33;
		ready_stall_pct = 33;
		r = $urandom_range(4096, 1 << 18);
		word = {$urandom, $urandom};
		word[THR_W-1:0] = THR_W'(longint'(r) * r);
		cfg_write(THR_IDX, word);
		run_meshes(140, r, 1'b0);
		wait_results_idle();

		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
